FILE: design/b64d_pkg.sv
// Shared types, codes and helper functions of the base64 line deframer.
// No dependencies; imported by every module of the block.
`default_nettype none

package b64d_pkg;

    localparam int DEF_LINE_MAX      = 256;
    localparam int DEF_PAYLOAD_BYTES = 24;
    localparam int NUM_WORDS         = 6;
    localparam int WORD_BYTES        = NUM_WORDS * 4;
    localparam int FIFO_DEPTH        = 4;
    localparam int CNT_MAX           = 255;

    localparam logic [7:0] NL_CHAR  = 8'h0A;
    localparam logic [7:0] CRC_POLY = 8'hD5;

    localparam logic [1:0] TOK_SEXTET = 2'd0;
    localparam logic [1:0] TOK_NL     = 2'd1;
    localparam logic [1:0] TOK_DROP   = 2'd2;

    localparam logic [1:0] ST_GOOD      = 2'd0;
    localparam logic [1:0] ST_MISMATCH  = 2'd1;
    localparam logic [1:0] ST_TOO_SHORT = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] sextet;
    } t_tok;

    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } t_sextet;

    function automatic t_sextet sextet_of(input logic [7:0] c);
        t_sextet r;
        r.ok  = 1'b1;
        r.val = '0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r.val = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r.val = 6'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r.val = 6'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B) begin
            r.val = 6'd62;
        end else if (c == 8'h2F) begin
            r.val = 6'd63;
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (v[7]) begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: design/b64d_front.sv
// Front end: accepts characters, maps base64 sextets, tracks line length.
// Depends on b64d_pkg; feeds tokens into b64d_fifo.
`default_nettype none

module b64d_front #(
    parameter int LINE_MAX = b64d_pkg::DEF_LINE_MAX
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    input  wire [7:0]        i_char_in,
    input  wire              i_full,
    output logic             o_stall,
    output logic             o_push,
    output b64d_pkg::t_tok   o_tok
);
    import b64d_pkg::*;

    localparam int LC_W = $clog2(LINE_MAX);

    logic [LC_W-1:0] r_line_count, n_line_count;
    logic            r_stopped, n_stopped;
    logic            accept;
    t_sextet         sx;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign sx      = sextet_of(i_char_in);

    always_comb begin
        n_line_count = r_line_count;
        n_stopped    = r_stopped;
        o_push       = 1'b0;
        o_tok.kind   = TOK_SEXTET;
        o_tok.sextet = sx.val;
        if (accept) begin
            if (i_char_in == NL_CHAR) begin
                o_push       = 1'b1;
                o_tok.kind   = TOK_NL;
                n_line_count = '0;
                n_stopped    = 1'b0;
            end else if (r_line_count == LC_W'(LINE_MAX - 1)) begin
                o_push       = 1'b1;
                o_tok.kind   = TOK_DROP;
                n_line_count = '0;
                n_stopped    = 1'b0;
            end else begin
                n_line_count = r_line_count + 1'b1;
                if (!r_stopped) begin
                    if (sx.ok) begin
                        o_push = 1'b1;
                    end else begin
                        n_stopped = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_count <= '0;
            r_stopped    <= 1'b0;
        end else begin
            r_line_count <= n_line_count;
            r_stopped    <= n_stopped;
        end
    end

endmodule

`default_nettype wire

FILE: design/b64d_fifo.sv
// Short token queue between front end and back end.
// Depends on b64d_pkg for the token type and depth.
`default_nettype none

module b64d_fifo (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  b64d_pkg::t_tok  i_tok,
    input  wire             i_pop,
    output logic            o_full,
    output logic            o_valid,
    output b64d_pkg::t_tok  o_tok
);
    import b64d_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    t_tok             r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_tok   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: design/b64d_back.sv
// Back end: assembles base64 groups into bytes, runs CRC-8, keeps the payload
// bytes and builds the status result. Depends on b64d_pkg.
`default_nettype none

module b64d_back #(
    parameter int PAYLOAD_BYTES = b64d_pkg::DEF_PAYLOAD_BYTES
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_tok_valid,
    input  b64d_pkg::t_tok  i_tok,
    output logic            o_tok_pop,
    input  wire             i_stall,
    output logic            o_valid,
    output logic [1:0]      o_status,
    output logic [31:0]     o_accel_x,
    output logic [31:0]     o_accel_y,
    output logic [31:0]     o_accel_z,
    output logic [31:0]     o_gyro_x,
    output logic [31:0]     o_gyro_y,
    output logic [31:0]     o_gyro_z
);
    import b64d_pkg::*;

    logic [17:0] r_acc, n_acc;
    logic [1:0]  r_gpos, n_gpos;
    logic [7:0]  r_count, n_count;
    logic [7:0]  r_crc, n_crc;
    logic [7:0]  r_held, n_held;
    logic [7:0]  r_store [PAYLOAD_BYTES];
    logic [7:0]  n_store [PAYLOAD_BYTES];
    logic [7:0]  pad [WORD_BYTES];

    logic        out_free;
    logic        proc;
    logic        is_nl;
    logic        do_clear;
    logic [1:0]  n_bytes;
    logic [7:0]  bytes [3];
    logic [8:0]  idx [3];
    logic        wr [3];

    logic        r_out_valid;
    logic [1:0]  r_status;
    logic [31:0] r_words [NUM_WORDS];
    logic [1:0]  res_status;

    assign out_free  = !r_out_valid || !i_stall;
    assign is_nl     = (i_tok.kind == TOK_NL);
    assign o_tok_pop = i_tok_valid && (!is_nl || out_free);
    assign proc      = o_tok_pop;

    always_comb begin
        logic [7:0] crc;
        logic [7:0] held;
        logic [7:0] cnt;
        n_acc    = r_acc;
        n_gpos   = r_gpos;
        do_clear = 1'b0;
        n_bytes  = 2'd0;
        bytes[0] = '0;
        bytes[1] = '0;
        bytes[2] = '0;
        if (proc) begin
            unique case (i_tok.kind)
                TOK_SEXTET: begin
                    if (r_gpos == 2'd3) begin
                        bytes[0] = r_acc[17:10];
                        bytes[1] = r_acc[9:2];
                        bytes[2] = {r_acc[1:0], i_tok.sextet};
                        n_bytes  = 2'd3;
                        n_acc    = '0;
                        n_gpos   = '0;
                    end else begin
                        n_acc  = {r_acc[11:0], i_tok.sextet};
                        n_gpos = r_gpos + 1'b1;
                    end
                end
                TOK_NL: begin
                    do_clear = 1'b1;
                    if (r_gpos == 2'd2) begin
                        bytes[0] = r_acc[11:4];
                        n_bytes  = 2'd1;
                    end else if (r_gpos == 2'd3) begin
                        bytes[0] = r_acc[17:10];
                        bytes[1] = r_acc[9:2];
                        n_bytes  = 2'd2;
                    end
                end
                default: begin
                    do_clear = 1'b1;
                end
            endcase
        end

        crc  = r_crc;
        held = r_held;
        cnt  = r_count;
        for (int j = 0; j < 3; j++) begin
            idx[j] = {1'b0, cnt};
            wr[j]  = (2'(j) < n_bytes) && ({1'b0, cnt} < 9'(PAYLOAD_BYTES));
            if (2'(j) < n_bytes) begin
                if (cnt != '0) begin
                    crc = crc8_byte(crc, held);
                end
                held = bytes[j];
                if (cnt != 8'(CNT_MAX)) begin
                    cnt = cnt + 1'b1;
                end
            end
        end
        n_crc   = crc;
        n_held  = held;
        n_count = cnt;

        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            n_store[i] = r_store[i];
            for (int j = 0; j < 3; j++) begin
                if (wr[j] && idx[j] == 9'(i)) begin
                    n_store[i] = bytes[j];
                end
            end
        end

        if ({1'b0, n_count} < 9'(PAYLOAD_BYTES + 1)) begin
            res_status = ST_TOO_SHORT;
        end else if (n_crc != n_held) begin
            res_status = ST_MISMATCH;
        end else begin
            res_status = ST_GOOD;
        end
    end

    for (genvar g = 0; g < WORD_BYTES; g++) begin : g_pad
        if (g < PAYLOAD_BYTES) begin : g_in
            assign pad[g] = n_store[g];
        end else begin : g_out
            assign pad[g] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            r_store[i] <= n_store[i];
        end
        if (proc && is_nl) begin
            r_status <= res_status;
            for (int k = 0; k < NUM_WORDS; k++) begin
                if (res_status == ST_GOOD) begin
                    r_words[k] <= {pad[4*k], pad[4*k+1], pad[4*k+2], pad[4*k+3]};
                end else begin
                    r_words[k] <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_gpos      <= '0;
            r_count     <= '0;
            r_crc       <= '0;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (do_clear) begin
                r_acc   <= '0;
                r_gpos  <= '0;
                r_count <= '0;
                r_crc   <= '0;
                r_held  <= '0;
            end else begin
                r_acc   <= n_acc;
                r_gpos  <= n_gpos;
                r_count <= n_count;
                r_crc   <= n_crc;
                r_held  <= n_held;
            end
            if (proc && is_nl) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid   = r_out_valid;
    assign o_status  = r_status;
    assign o_accel_x = r_words[0];
    assign o_accel_y = r_words[1];
    assign o_accel_z = r_words[2];
    assign o_gyro_x  = r_words[3];
    assign o_gyro_y  = r_words[4];
    assign o_gyro_z  = r_words[5];

`ifndef SYNTHESIS
    a_pop_needs_tok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tok_pop |-> i_tok_valid)
        else $error("token popped from empty queue");

    a_nl_not_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tok_pop && i_tok.kind == TOK_NL) |-> !(r_out_valid && i_stall))
        else $error("newline consumed while result register is held");

    a_line_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tok_pop && (i_tok.kind == TOK_NL || i_tok.kind == TOK_DROP))
        |=> (r_gpos == '0 && r_count == '0 && r_crc == '0))
        else $error("line state not cleared after line end");

    a_result_after_nl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |-> $past(o_tok_pop && is_nl))
        else $error("result appeared without a newline");
`endif

endmodule

`default_nettype wire

FILE: design/base64_crc8_line_deframer_core.sv
// Top level of the base64 line deframer with CRC-8 (poly 0xD5) check.
// Depends on b64d_pkg, b64d_front, b64d_fifo and b64d_back.
//
// One character is accepted per clock cycle unless the queue is full. The
// front end classifies each character and pushes sextet, newline or line-drop
// tokens into a 4-entry queue; the back end retires one token per cycle unless
// a newline is held back, decoding a full group of four sextets into three
// bytes with the CRC and payload store updated in the same cycle. A newline's
// status and six payload words are loaded into the output register when its
// token leaves the queue, so a newline passes the queue register and then the
// output register. The only throughput limit is the output register: a newline
// token waits in the queue while a previous result is held by i_stall
// backpressure, and input stalls once the queue fills.
`default_nettype none

module base64_crc8_line_deframer_core #(
    parameter int LINE_MAX      = b64d_pkg::DEF_LINE_MAX,
    parameter int PAYLOAD_BYTES = b64d_pkg::DEF_PAYLOAD_BYTES
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire [7:0]   i_char_in,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_accel_x,
    output logic [31:0] o_accel_y,
    output logic [31:0] o_accel_z,
    output logic [31:0] o_gyro_x,
    output logic [31:0] o_gyro_y,
    output logic [31:0] o_gyro_z
);
    import b64d_pkg::*;

    logic push;
    logic full;
    logic q_valid;
    logic pop;
    t_tok in_tok;
    t_tok q_tok;

    b64d_front #(
        .LINE_MAX (LINE_MAX)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_char_in (i_char_in),
        .i_full    (full),
        .o_stall   (o_stall),
        .o_push    (push),
        .o_tok     (in_tok)
    );

    b64d_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_tok   (in_tok),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_tok   (q_tok)
    );

    b64d_back #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (q_valid),
        .i_tok       (q_tok),
        .o_tok_pop   (pop),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_accel_x   (o_accel_x),
        .o_accel_y   (o_accel_y),
        .o_accel_z   (o_accel_z),
        .o_gyro_x    (o_gyro_x),
        .o_gyro_y    (o_gyro_y),
        .o_gyro_z    (o_gyro_z)
    );

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// Testbench for base64_crc8_line_deframer_core: a table of directed lines, then random lines.
// Each result is checked against a line-decoding predictor. Depends on b64d_pkg and the core.
`timescale 1ns / 100ps

module testbench;
    import b64d_pkg::*;

    localparam int PB      = DEF_PAYLOAD_BYTES;
    localparam int LN_MAX  = DEF_LINE_MAX;
    localparam int N_CHARS = 1900;
    localparam string B64_ALPHA =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef logic [7:0] t_char_q[$];

    typedef struct packed {
        logic [1:0]       status;
        logic [5:0][31:0] words;
    } t_frame;

    typedef struct packed {
        logic [7:0] c;
        bit         fixed;
        logic [1:0] status;
    } t_stim;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_char_in = 8'h00;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [31:0] o_accel_x, o_accel_y, o_accel_z, o_gyro_x, o_gyro_y, o_gyro_z;

    t_frame pending_frames[$];
    t_stim  stim_tab[$];
    int     err_count = 0;
    int     sent_chars = 0;
    bit     quiet = 1'b0;
    string  word_name[6] = '{"accel_x", "accel_y", "accel_z", "gyro_x", "gyro_y", "gyro_z"};

    // predictor state for the current line
    int         ln_len;
    logic [17:0] ln_acc;
    logic [1:0] ln_gpos;
    bit         ln_stop;
    logic [7:0] ln_nbytes;
    logic [7:0] ln_crc;
    logic [7:0] ln_held;
    logic [7:0] ln_payload[PB];

    base64_crc8_line_deframer_core dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_char_in (i_char_in),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_status  (o_status),
        .o_accel_x (o_accel_x),
        .o_accel_y (o_accel_y),
        .o_accel_z (o_accel_z),
        .o_gyro_x  (o_gyro_x),
        .o_gyro_y  (o_gyro_y),
        .o_gyro_z  (o_gyro_z)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int sextet_val(input logic [7:0] c);
        if (c inside {[8'h41:8'h5A]}) return int'(c) - 'h41;
        if (c inside {[8'h61:8'h7A]}) return int'(c) - 'h61 + 26;
        if (c inside {[8'h30:8'h39]}) return int'(c) - 'h30 + 52;
        if (c == 8'h2B) return 62;
        if (c == 8'h2F) return 63;
        return -1;
    endfunction

    // MSB-first CRC-8, poly 0xD5, one data bit per step
    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] r;
        logic       fb;
        r = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = r[7] ^ b[i];
            r  = {r[6:0], 1'b0} ^ (fb ? 8'hD5 : 8'h00);
        end
        return r;
    endfunction

    function automatic void line_clear();
        ln_len    = 0;
        ln_acc    = '0;
        ln_gpos   = '0;
        ln_stop   = 1'b0;
        ln_nbytes = '0;
        ln_crc    = '0;
        ln_held   = '0;
    endfunction

    function automatic void line_take(input logic [7:0] b);
        if (ln_nbytes != 0) ln_crc = crc8_next(ln_crc, ln_held);
        ln_held = b;
        if (ln_nbytes < PB) ln_payload[ln_nbytes] = b;
        if (ln_nbytes != 8'd255) ln_nbytes++;
    endfunction

    // returns 1 when the character closes a line and yields a frame
    function automatic bit deframe_step(input logic [7:0] c, output t_frame f);
        int          s;
        logic [23:0] g;
        logic [7:0]  b;
        f = '0;
        if (c != NL_CHAR) begin
            if (!ln_stop) begin
                s = sextet_val(c);
                if (s < 0) begin
                    ln_stop = 1'b1;
                end else if (ln_gpos == 2'd3) begin
                    g = {ln_acc, 6'(s)};
                    line_take(g[23:16]);
                    line_take(g[15:8]);
                    line_take(g[7:0]);
                    ln_acc  = '0;
                    ln_gpos = '0;
                end else begin
                    ln_acc = {ln_acc[11:0], 6'(s)};
                    ln_gpos++;
                end
            end
            ln_len++;
            if (ln_len >= LN_MAX) line_clear();
            return 1'b0;
        end
        if (ln_gpos == 2'd2) begin
            line_take(ln_acc[11:4]);
        end else if (ln_gpos == 2'd3) begin
            line_take(ln_acc[17:10]);
            line_take(ln_acc[9:2]);
        end
        if (ln_nbytes < PB + 1) begin
            f.status = ST_TOO_SHORT;
        end else if (ln_crc != ln_held) begin
            f.status = ST_MISMATCH;
        end else begin
            f.status = ST_GOOD;
            for (int k = 0; k < 6; k++) begin
                for (int j = 0; j < 4; j++) begin
                    b = (k * 4 + j < PB) ? ln_payload[k * 4 + j] : 8'h00;
                    f.words[k] = {f.words[k][23:0], b};
                end
            end
        end
        line_clear();
        return 1'b1;
    endfunction

    function automatic t_char_q b64_encode(input t_char_q bytes);
        t_char_q     r;
        logic [23:0] v;
        int          n;
        int          i;
        n = bytes.size();
        for (i = 0; i + 2 < n; i += 3) begin
            v = {bytes[i], bytes[i + 1], bytes[i + 2]};
            for (int k = 3; k >= 0; k--) r.push_back(B64_ALPHA[v[k * 6 +: 6]]);
        end
        if (n - i == 1) begin
            v = {bytes[i], 16'h0000};
            r.push_back(B64_ALPHA[v[23:18]]);
            r.push_back(B64_ALPHA[v[17:12]]);
        end else if (n - i == 2) begin
            v = {bytes[i], bytes[i + 1], 8'h00};
            r.push_back(B64_ALPHA[v[23:18]]);
            r.push_back(B64_ALPHA[v[17:12]]);
            r.push_back(B64_ALPHA[v[11:6]]);
        end
        return r;
    endfunction

    function automatic t_char_q with_crc(input t_char_q bytes);
        t_char_q    r;
        logic [7:0] crc;
        r   = bytes;
        crc = 8'h00;
        foreach (bytes[i]) crc = crc8_next(crc, bytes[i]);
        r.push_back(crc);
        return r;
    endfunction

    function automatic t_char_q rand_bytes(input int n);
        t_char_q r;
        for (int i = 0; i < n; i++) r.push_back(8'($urandom));
        return r;
    endfunction

    function automatic t_char_q fill_chars(input logic [7:0] c, input int n);
        t_char_q r;
        for (int i = 0; i < n; i++) r.push_back(c);
        return r;
    endfunction

    function automatic logic [7:0] rand_non_nl();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == NL_CHAR);
        return c;
    endfunction

    function automatic logic [7:0] rand_stopper();
        logic [7:0] c;
        do c = rand_non_nl(); while (sextet_val(c) >= 0);
        return c;
    endfunction

    function automatic void add_line(input t_char_q chars, input bit nl, input bit fixed,
                                     input logic [1:0] st);
        foreach (chars[i]) stim_tab.push_back('{chars[i], 1'b0, ST_GOOD});
        if (nl) stim_tab.push_back('{NL_CHAR, fixed, st});
    endfunction

    function automatic t_char_q rand_line();
        t_char_q ln;
        int      kind;
        int      n;
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            ln = b64_encode(with_crc(rand_bytes(PB + $urandom_range(0, 3))));
            if (kind >= 55)
                ln[$urandom_range(0, ln.size() - 1)] = B64_ALPHA[$urandom_range(0, 63)];
            case ($urandom_range(0, 3))
                0: ln.push_back(8'h3D);
                1: begin
                    ln.push_back(rand_stopper());
                    n = $urandom_range(0, 6);
                    for (int i = 0; i < n; i++) ln.push_back(rand_non_nl());
                end
                default: ;
            endcase
        end else if (kind < 80) begin
            n = $urandom_range(0, PB);
            ln = $urandom_range(0, 1) ? b64_encode(with_crc(rand_bytes(n)))
                                      : b64_encode(rand_bytes(n));
            if ($urandom_range(0, 1)) ln.push_back(B64_ALPHA[$urandom_range(0, 63)]);
        end else if (kind < 96) begin
            n = $urandom_range(0, 40);
            for (int i = 0; i < n; i++) ln.push_back(rand_non_nl());
        end else begin
            n = $urandom_range(LN_MAX, LN_MAX + 40);
            for (int i = 0; i < n; i++)
                ln.push_back($urandom_range(0, 9) == 0 ? rand_non_nl()
                                                       : B64_ALPHA[$urandom_range(0, 63)]);
        end
        ln.push_back(NL_CHAR);
        return ln;
    endfunction

    task automatic send_char(input logic [7:0] c, input bit fixed, input logic [1:0] fixed_st);
        t_frame f;
        while (!quiet && $urandom_range(0, 99) < 23) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_char_in <= c;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (deframe_step(c, f)) begin
            if (fixed) begin
                f        = '0;
                f.status = fixed_st;
            end
            pending_frames.push_back(f);
        end
        sent_chars++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_frame();
        t_frame exp;
        t_frame act;
        if (pending_frames.size() == 0) begin
            $error("unexpected frame: status %0d", o_status);
            err_count++;
            return;
        end
        exp       = pending_frames.pop_front();
        act.status = o_status;
        act.words  = {o_gyro_z, o_gyro_y, o_gyro_x, o_accel_z, o_accel_y, o_accel_x};
        if (act.status !== exp.status) begin
            $error("status: expected %0d, got %0d", exp.status, act.status);
            err_count++;
        end
        for (int k = 0; k < 6; k++) begin
            if (act.words[k] !== exp.words[k]) begin
                $error("%s: expected %08h, got %08h", word_name[k], exp.words[k], act.words[k]);
                err_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) check_frame();
        i_stall <= !quiet && ($urandom_range(0, 99) < 23);
    end

    initial begin
        t_char_q pl;
        t_char_q tmp;
        t_char_q ln;
        int      nlines;

        line_clear();
        foreach (ln_payload[i]) ln_payload[i] = 8'h00;

        // directed table
        tmp.delete();
        add_line(tmp, 1, 1, ST_TOO_SHORT);
        tmp = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h21};
        add_line(tmp, 1, 1, ST_TOO_SHORT);
        add_line(fill_chars("A", 36), 1, 1, ST_GOOD);
        tmp = fill_chars("A", 35);
        tmp.push_back("B");
        add_line(tmp, 1, 1, ST_MISMATCH);
        add_line(b64_encode(with_crc(rand_bytes(PB - 1))), 1, 1, ST_TOO_SHORT);
        add_line(b64_encode(with_crc(fill_chars(8'hFF, PB))), 1, 0, ST_GOOD);
        pl = '{8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
               8'h80, 8'h00, 8'h00, 8'h00, 8'h7F, 8'hFF, 8'hFF, 8'hFF,
               8'h3F, 8'h80, 8'h00, 8'h00, 8'hBF, 8'h80, 8'h00, 8'h00, 8'h5A};
        add_line(b64_encode(with_crc(pl)), 1, 0, ST_GOOD);
        tmp = b64_encode(with_crc(rand_bytes(PB + 2)));
        tmp.push_back(8'h3D);
        tmp.push_back(8'h0D);
        add_line(tmp, 1, 0, ST_GOOD);
        tmp = b64_encode(with_crc(rand_bytes(PB + 2)));
        tmp.push_back("Q");
        add_line(tmp, 1, 0, ST_GOOD);
        tmp = b64_encode(with_crc(rand_bytes(PB)));
        tmp.push_back("-");
        tmp = {tmp, fill_chars("z", 8)};
        add_line(tmp, 1, 0, ST_GOOD);
        pl = with_crc(rand_bytes(PB));
        pl[PB] = pl[PB] ^ 8'h01;
        add_line(b64_encode(pl), 1, 0, ST_GOOD);
        tmp.delete();
        for (int i = 0; i < 64; i++) tmp.push_back(B64_ALPHA[i]);
        add_line(tmp, 1, 0, ST_GOOD);
        // overflow drops the line silently, then a clean frame follows
        add_line(fill_chars("A", LN_MAX), 0, 0, ST_GOOD);
        add_line(b64_encode(with_crc(rand_bytes(PB + 1))), 1, 0, ST_GOOD);
        tmp = b64_encode(with_crc(rand_bytes(PB + 3)));
        tmp.push_back(".");
        tmp = {tmp, fill_chars("A", LN_MAX - 1 - tmp.size())};
        add_line(tmp, 1, 0, ST_GOOD);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_tab[i]) send_char(stim_tab[i].c, stim_tab[i].fixed, stim_tab[i].status);
        drain();

        nlines = 0;
        while (sent_chars < N_CHARS) begin
            quiet = (nlines >= 4 && nlines < 14);
            if (nlines == 2) drain();
            ln = rand_line();
            foreach (ln[i]) send_char(ln[i], 1'b0, ST_GOOD);
            nlines++;
        end
        quiet = 1'b0;

        drain();
        repeat (20) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
